// ===== sv/bdq_pkg.sv =====
// Package for the bounded deque: item types, codes and cell control.
package bdq_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned VAL_W        = 32;
	localparam int unsigned POS_W        = 4;
	localparam int unsigned COUNT_W      = 5;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_SEARCH     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} stat_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [VAL_W-1:0]  item_value;
	} req_t;

	typedef struct packed {
		stat_t                    status;
		logic signed [VAL_W-1:0]  result_value;
		logic [POS_W-1:0]         position;
		logic [COUNT_W-1:0]       entry_count;
	} rsp_t;

	// What a cell does with its value this cycle.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_SHR   = 2'd1,
		CELL_SHL   = 2'd2,
		CELL_LOAD  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     cmp_en;
	} cell_ctrl_t;

endpackage

// ===== sv/bdq_cell.sv =====
// One storage cell of the deque chain: a value, its neighbor moves and a match flag.
module bdq_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bdq_pkg::cell_ctrl_t              ctrl,
	input  logic signed [bdq_pkg::VAL_W-1:0] front_data,
	input  logic signed [bdq_pkg::VAL_W-1:0] back_data,
	input  logic signed [bdq_pkg::VAL_W-1:0] load_data,
	input  logic signed [bdq_pkg::VAL_W-1:0] key,
	output logic signed [bdq_pkg::VAL_W-1:0] data,
	output logic                             match
);

	logic signed [bdq_pkg::VAL_W-1:0] data_q;
	logic                             match_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			bdq_pkg::CELL_SHR:  data_q <= front_data;
			bdq_pkg::CELL_SHL:  data_q <= back_data;
			bdq_pkg::CELL_LOAD: data_q <= load_data;
			default:            data_q <= data_q;
		endcase
	end

	// Latch the compare so the priority pick sees a registered row of flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			match_q <= (data_q == key);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

// ===== sv/bounded_deque_with_search.sv =====
// Top level of the bounded deque with search: cell chain, sequencer and result register.
//
// Usage: a request item on req (req_valid/req_ready) carries a command and a
// 32-bit value: push front, push back, pop front, or search for the first
// entry from the front equal to the value. Every request gives exactly one
// response item on rsp (rsp_valid/rsp_ready) with a status, the popped or
// found value, the match position and the entry count after the command.
//
// Entries live in a chain of CAPACITY cells, front entry in cell 0. Push
// front shifts the whole chain one cell back, pop front shifts it one cell
// forward, push back loads the cell just past the last entry. Search makes
// every cell compare its value to the key in the same cycle, latches the
// flags in the cells, then picks the first flag among occupied cells.
//
// Push and pop finish in ST_EXEC once the output register is free (cells and
// response register update at the same edge); search goes on through the
// registered match row in ST_FIND before its response is written.
//
// Reset empties the store; cell contents are not cleared. When the receiver
// stalls, one finished response waits in the output register and the next
// request is still accepted; its own completion then holds until rsp drains.
module bounded_deque_with_search #(
	parameter int unsigned CAPACITY = bdq_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bdq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bdq_pkg::rsp_t rsp
);

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_FIND = 3'b100
	} state_t;

	state_t                           state_q;
	bdq_pkg::cmd_t                    cmd_q;
	logic signed [bdq_pkg::VAL_W-1:0] val_q;
	logic [CNT_W-1:0]                 count_q;
	logic                             rsp_valid_q;
	bdq_pkg::rsp_t                    rsp_q;

	bdq_pkg::cell_ctrl_t              cell_ctrl [CAPACITY];
	logic signed [bdq_pkg::VAL_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]              cell_match;

	logic             out_free;
	logic             full;
	logic             empty;
	logic             commit;
	logic [CNT_W-1:0] count_next;
	bdq_pkg::rsp_t    rsp_next;
	logic             found;
	logic [IDX_W-1:0] found_idx;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign req_ready = (state_q == ST_IDLE);

	// Per-cell control: shift the chain on front push and pop, load one
	// cell on back push, compare everywhere on search.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_ctrl[i].op     = bdq_pkg::CELL_HOLD;
			cell_ctrl[i].cmp_en = (state_q == ST_EXEC) && (cmd_q == bdq_pkg::CMD_SEARCH);
			if (state_q == ST_EXEC && out_free) begin
				unique case (cmd_q)
					bdq_pkg::CMD_PUSH_FRONT: begin
						if (!full) cell_ctrl[i].op = bdq_pkg::CELL_SHR;
					end
					bdq_pkg::CMD_PUSH_BACK: begin
						if (!full && count_q[IDX_W-1:0] == IDX_W'(i))
							cell_ctrl[i].op = bdq_pkg::CELL_LOAD;
					end
					bdq_pkg::CMD_POP_FRONT: begin
						if (!empty) cell_ctrl[i].op = bdq_pkg::CELL_SHL;
					end
					default: begin
						cell_ctrl[i].op = bdq_pkg::CELL_HOLD;
					end
				endcase
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [bdq_pkg::VAL_W-1:0] front_d;
		logic signed [bdq_pkg::VAL_W-1:0] back_d;

		if (i == 0) begin : g_head
			assign front_d = val_q;
		end else begin : g_mid
			assign front_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign back_d = cell_data[i];
		end else begin : g_inner
			assign back_d = cell_data[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl[i]),
			.front_data (front_d),
			.back_data  (back_d),
			.load_data  (val_q),
			.key        (val_q),
			.data       (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	// Pick the first latched match among occupied cells.
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i] && (CNT_W'(i) < count_q)) begin
				found     = 1'b1;
				found_idx = IDX_W'(i);
			end
		end
	end

	// Build the response and the new count for the finishing command.
	always_comb begin
		count_next            = count_q;
		rsp_next.status       = bdq_pkg::STAT_OK;
		rsp_next.result_value = '0;
		rsp_next.position     = '0;
		commit                = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				commit = out_free && (cmd_q != bdq_pkg::CMD_SEARCH);
				unique case (cmd_q) inside
					bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
						if (full) rsp_next.status = bdq_pkg::STAT_FULL;
						else count_next = count_q + CNT_W'(1);
					end
					bdq_pkg::CMD_POP_FRONT: begin
						if (empty) begin
							rsp_next.status = bdq_pkg::STAT_EMPTY;
						end else begin
							count_next            = count_q - CNT_W'(1);
							rsp_next.result_value = cell_data[0];
						end
					end
					default: begin
						rsp_next.status = bdq_pkg::STAT_NOT_FOUND;
					end
				endcase
			end
			ST_FIND: begin
				commit = out_free;
				if (found) begin
					rsp_next.result_value = val_q;
					rsp_next.position     = bdq_pkg::POS_W'(found_idx);
				end else begin
					rsp_next.status = bdq_pkg::STAT_NOT_FOUND;
				end
			end
			default: begin
				commit = 1'b0;
			end
		endcase
		rsp_next.entry_count = bdq_pkg::COUNT_W'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					// Search goes on to the pick; others finish once the output frees.
					if (cmd_q == bdq_pkg::CMD_SEARCH) state_q <= ST_FIND;
					else if (commit) state_q <= ST_IDLE;
				end
				ST_FIND: begin
					if (commit) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the request; hold the response until it is taken.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= req.command;
			val_q <= req.item_value;
		end
		if (commit) rsp_q <= rsp_next;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
